>>> rtl/wgm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

  // Default store capacities
  localparam int unsigned MAX_PATTERN_DEF = 64;
  localparam int unsigned MAX_TEXT_DEF    = 64;

  localparam int unsigned BYTE_W = 8;

  // Wildcard bytes: '?' and '*'
  localparam logic [BYTE_W-1:0] ANY_ONE = 8'h3F;
  localparam logic [BYTE_W-1:0] ANY_RUN = 8'h2A;

  // Item actions
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PAT   = 2'd1,
    ACT_TXT   = 2'd2,
    ACT_EVAL  = 2'd3
  } action_e;

  // Walk sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } walk_state_e;

  // Walker status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic matched;
  } walk_stat_t;

endpackage

>>> rtl/wgm_mem.sv
`timescale 1ns / 1ps
// Byte store with one write port and one registered read port.
module wgm_mem #(
  parameter int unsigned DEPTH = wgm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [wgm_pkg::BYTE_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [wgm_pkg::BYTE_W-1:0]  rdata_o
);

  logic [wgm_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [wgm_pkg::BYTE_W-1:0] rdata_q;

  // Write one byte, read one byte per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wgm_walk.sv
`timescale 1ns / 1ps
// Match sequencer: steps one shared byte compare over both stores.
module wgm_walk #(
  parameter int unsigned MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_TEXT    = wgm_pkg::MAX_TEXT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] plen_i,
  input  logic [$clog2(MAX_TEXT+1)-1:0]    tlen_i,
  output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_raddr_o,
  input  logic [wgm_pkg::BYTE_W-1:0]     pat_rdata_i,
  output logic [((MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1)-1:0] txt_raddr_o,
  input  logic [wgm_pkg::BYTE_W-1:0]     txt_rdata_i,
  input  logic                           res_take_i,
  output wgm_pkg::walk_stat_t            stat_o
);

  localparam int unsigned PLW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned TLW = $clog2(MAX_TEXT + 1);
  localparam int unsigned PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

  wgm_pkg::walk_state_e st_q, st_d;
  logic [PLW-1:0] p_q, p_d;
  logic [PLW-1:0] star_q, star_d;
  logic [TLW-1:0] t_q, t_d;
  logic [TLW-1:0] resume_q, resume_d;
  logic           have_q, have_d;
  logic           match_q, match_d;

  logic p_in, t_in;
  logic is_run, hit;

  assign p_in = (p_q < plen_i);
  assign t_in = (t_q < tlen_i);

  // Keep read addresses inside the stores
  assign pat_raddr_o = p_in ? p_q[PAW-1:0] : '0;
  assign txt_raddr_o = t_in ? t_q[TAW-1:0] : '0;

  // Shared byte compare
  assign is_run = p_in && (pat_rdata_i == wgm_pkg::ANY_RUN);
  assign hit    = p_in && ((pat_rdata_i == wgm_pkg::ANY_ONE) || (pat_rdata_i == txt_rdata_i));

  // Next step of the walk
  always_comb begin
    st_d     = st_q;
    p_d      = p_q;
    star_d   = star_q;
    t_d      = t_q;
    resume_d = resume_q;
    have_d   = have_q;
    match_d  = match_q;
    case (st_q)
      wgm_pkg::ST_IDLE: begin
        if (start_i) begin
          p_d      = '0;
          star_d   = '0;
          t_d      = '0;
          resume_d = '0;
          have_d   = 1'b0;
          st_d     = wgm_pkg::ST_FETCH;
        end
      end
      wgm_pkg::ST_FETCH: begin
        st_d = wgm_pkg::ST_DECIDE;
      end
      wgm_pkg::ST_DECIDE: begin
        st_d = wgm_pkg::ST_FETCH;
        if (t_in) begin
          if (is_run) begin
            // Remember the star and try an empty run first
            have_d   = 1'b1;
            star_d   = p_q;
            p_d      = p_q + PLW'(1);
            resume_d = t_q;
          end else if (hit) begin
            p_d = p_q + PLW'(1);
            t_d = t_q + TLW'(1);
          end else if (have_q) begin
            // Back up: let the last star swallow one more byte
            p_d      = star_q + PLW'(1);
            resume_d = resume_q + TLW'(1);
            t_d      = resume_q + TLW'(1);
          end else begin
            match_d = 1'b0;
            st_d    = wgm_pkg::ST_DONE;
          end
        end else begin
          // Text used up: skip trailing stars
          if (is_run) begin
            p_d = p_q + PLW'(1);
          end else begin
            match_d = (p_q == plen_i);
            st_d    = wgm_pkg::ST_DONE;
          end
        end
      end
      wgm_pkg::ST_DONE: begin
        if (res_take_i) begin
          st_d = wgm_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = wgm_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wgm_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Walk pointers and result
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    star_q   <= star_d;
    t_q      <= t_d;
    resume_q <= resume_d;
    have_q   <= have_d;
    match_q  <= match_d;
  end

  assign stat_o.busy    = (st_q != wgm_pkg::ST_IDLE);
  assign stat_o.done    = (st_q == wgm_pkg::ST_DONE);
  assign stat_o.matched = match_q;

`ifndef SYNTH
  a_p_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == wgm_pkg::ST_DECIDE) |-> (p_q <= plen_i))
    else $error("pattern pointer past pattern length");

  a_t_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == wgm_pkg::ST_DECIDE) |-> (t_q <= tlen_i))
    else $error("text pointer past text length");

  a_star_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == wgm_pkg::ST_DECIDE) && have_q) |-> (star_q < p_q) && (resume_q <= t_q))
    else $error("backtrack point ahead of walk");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.done && !res_take_i) |=> (stat_o.done && $stable(match_q)))
    else $error("finished result lost before transfer");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (st_q == wgm_pkg::ST_IDLE))
    else $error("walk started while busy");
`endif

endmodule

>>> rtl/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// Top level of the wildcard glob matcher: stores, lengths, walker and result register.
//
//  Channel | Ports                                   | Transfer when
//  --------+-----------------------------------------+------------------------------
//  in      | in_valid_i, in_ready_o, action_i,       | in_valid_i && in_ready_o
//          | char_value_i                            |
//  out     | out_valid_o, out_ready_i, matched_o,    | out_valid_o && out_ready_i
//          | overflowed_o                            |
//
//  Clear and append items never hold the input; a byte is written in the cycle it transfers.
//  An evaluate runs S walk steps (at most about text_length * pattern_length +
//  pattern_length), each a registered store read followed by one shared compare.
//  The input stays not ready until the result moves into the output register, which
//  waits while that register still holds a result that has not been taken.
//  Reset clears lengths, overflow flag, walker state and output valid; store contents stay.
module wildcard_glob_matcher #(
  parameter int unsigned MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_TEXT    = wgm_pkg::MAX_TEXT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [wgm_pkg::BYTE_W-1:0]    char_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic                          overflowed_o
);

  localparam int unsigned PLW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned TLW = $clog2(MAX_TEXT + 1);
  localparam int unsigned PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned TAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

  logic [PLW-1:0] plen_q;
  logic [TLW-1:0] tlen_q;
  logic           ovf_q;
  logic           out_valid_q, matched_q, overflowed_q;

  wgm_pkg::action_e    act;
  wgm_pkg::walk_stat_t stat;
  logic                in_xfer, res_take;
  logic                pat_full, txt_full;
  logic                pat_we, txt_we, start;
  logic [PAW-1:0]      pat_raddr;
  logic [TAW-1:0]      txt_raddr;
  logic [wgm_pkg::BYTE_W-1:0] pat_rdata, txt_rdata;

  assign act      = wgm_pkg::action_e'(action_i);
  assign in_ready_o = !stat.busy;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign pat_full = (plen_q == PLW'(MAX_PATTERN));
  assign txt_full = (tlen_q == TLW'(MAX_TEXT));
  assign pat_we   = in_xfer && (act == wgm_pkg::ACT_PAT) && !pat_full;
  assign txt_we   = in_xfer && (act == wgm_pkg::ACT_TXT) && !txt_full;
  assign start    = in_xfer && (act == wgm_pkg::ACT_EVAL);
  assign res_take = stat.done && (!out_valid_q || out_ready_i);

  // Track lengths and the sticky drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      tlen_q <= '0;
      ovf_q  <= 1'b0;
    end else if (in_xfer) begin
      case (act)
        wgm_pkg::ACT_CLEAR: begin
          plen_q <= '0;
          tlen_q <= '0;
          ovf_q  <= 1'b0;
        end
        wgm_pkg::ACT_PAT: begin
          if (pat_full) begin
            ovf_q <= 1'b1;
          end else begin
            plen_q <= plen_q + PLW'(1);
          end
        end
        wgm_pkg::ACT_TXT: begin
          if (txt_full) begin
            ovf_q <= 1'b1;
          end else begin
            tlen_q <= tlen_q + TLW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  wgm_mem #(
    .DEPTH (MAX_PATTERN),
    .AW    (PAW)
  ) u_pat_mem (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (plen_q[PAW-1:0]),
    .wdata_i (char_value_i),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  wgm_mem #(
    .DEPTH (MAX_TEXT),
    .AW    (TAW)
  ) u_txt_mem (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (tlen_q[TAW-1:0]),
    .wdata_i (char_value_i),
    .raddr_i (txt_raddr),
    .rdata_o (txt_rdata)
  );

  wgm_walk #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .plen_i      (plen_q),
    .tlen_i      (tlen_q),
    .pat_raddr_o (pat_raddr),
    .pat_rdata_i (pat_rdata),
    .txt_raddr_o (txt_raddr),
    .txt_rdata_i (txt_rdata),
    .res_take_i  (res_take),
    .stat_o      (stat)
  );

  // Output valid: load on a finished walk, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      matched_q    <= stat.matched;
      overflowed_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign matched_o    = matched_q;
  assign overflowed_o = overflowed_q;

endmodule
